>>> src/scanner_status_frame_parser_unit_assert.svh
// assertion macros for the scanner status frame parser
`ifndef SCANNER_STATUS_FRAME_PARSER_UNIT_ASSERT_SVH
`define SCANNER_STATUS_FRAME_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SSFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssfp check failed");

// next-cycle implication, checked outside reset
`define SSFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssfp check failed");

`endif

>>> src/ssfp_pkg.sv
// package with codes and constants for the scanner status frame parser
package ssfp_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'h56;
   localparam logic [7:0] SYNC_SECOND = 8'hA1;
   localparam logic [1:0] SIDE_TOP    = 2'b01;
   localparam logic [1:0] SIDE_BOTTOM = 2'b10;
   localparam logic [1:0] DEFECT_NONE = 2'b00;
   localparam logic [1:0] DEFECT_ABS  = 2'b11;

   typedef enum logic [3:0] {
      PH_HUNT   = 4'd0,
      PH_STAT_A = 4'd1,
      PH_STAT_B = 4'd2,
      PH_HI_A   = 4'd3,
      PH_HI_B   = 4'd4,
      PH_LO_A   = 4'd5,
      PH_LO_B   = 4'd6,
      PH_MOT1   = 4'd7,
      PH_MOT2   = 4'd8,
      PH_MOT3   = 4'd9,
      PH_MOT4   = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      ST_GOOD     = 2'd0,
      ST_MISMATCH = 2'd1,
      ST_BAD_SIDE = 2'd2,
      ST_BAD_DEF  = 2'd3
   } status_type;

endpackage

>>> src/scanner_status_frame_parser_unit.sv
// scanner status frame parser top level
//
// req channel: one received serial byte per word (req_rx_byte), valid/ready.
// rsp channel: one word per finished frame, good or aborted, valid/ready.
// csr port: csr_write_enable / csr_write_data set the one-bit scan pass,
// taken at any edge outside reset with the enable high, no read-back.
// every accepted byte is decoded in the cycle it is taken; a frame word
// appears on rsp in the cycle after its last byte (or its failing byte).
// throughput is one byte per cycle while rsp does not stall, set by the single
// result register: req_ready is high while that register is empty or being taken.
// a stall on rsp holds the result register and drops req_ready until the
// word is taken; no byte is lost and no word is dropped.
// an error word carries only rsp_frame_status; other fields are zero.
// synchronous reset returns the parser to sync hunting, clears the change
// history and the scan pass, and empties the result register.
// reset needs no clearing pass; the block takes bytes from the next cycle.
module scanner_status_frame_parser_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_frame_status,
   output logic               rsp_side,
   output logic [3:0]         rsp_sensor_number,
   output logic               rsp_defect_raw,
   output logic               rsp_defect_reported,
   output logic signed [15:0] rsp_coordinate,
   output logic [7:0]         rsp_motor_one_position,
   output logic [7:0]         rsp_motor_two_position,
   output logic [7:0]         rsp_motor_three_position,
   output logic [7:0]         rsp_motor_four_position,
   output logic [1:0]         rsp_change_kind,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);

`include "scanner_status_frame_parser_unit_assert.svh"

   ssfp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  previous_byte_ff, previous_byte_in;
   logic [7:0]  pair_first_ff, pair_first_in;
   logic [7:0]  header_ff, header_in;
   logic [15:0] coord_ff, coord_in;
   logic [7:0]  motor1_ff, motor1_in;
   logic [7:0]  motor2_ff, motor2_in;
   logic [7:0]  motor3_ff, motor3_in;
   logic [5:0]  last_hdr_ff, last_hdr_in;
   logic [16:0] last_pos_ff, last_pos_in;
   logic        have_last_ff, have_last_in;
   logic        scan_pass_ff;

   logic        rsp_valid_ff;
   logic [1:0]  status_ff, status_in;
   logic        side_ff, side_in;
   logic [3:0]  sensor_ff, sensor_in;
   logic        draw_ff, draw_in;
   logic        drep_ff, drep_in;
   logic [15:0] coord_out_ff, coord_out_in;
   logic [7:0]  m1_ff, m1_in;
   logic [7:0]  m2_ff, m2_in;
   logic [7:0]  m3_ff, m3_in;
   logic [7:0]  m4_ff, m4_in;
   logic [1:0]  kind_ff, kind_in;

   logic        req_fire;
   logic        emit;
   logic [7:0]  b;
   logic [1:0]  sbits, dbits;
   logic        fr_side, fr_draw, fr_drep, near_zero;
   logic [5:0]  hmsg;
   logic [16:0] pmsg;
   logic [1:0]  kind;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign b         = req_rx_byte;
   assign sbits     = b[7:6];
   assign dbits     = b[5:4];

   // final-byte decode from stored header and coordinate
   assign fr_side   = (header_ff[7:6] == ssfp_pkg::SIDE_BOTTOM);
   assign fr_draw   = (header_ff[5:4] == ssfp_pkg::DEFECT_ABS);
   assign near_zero = (coord_ff == 16'h0000) || (coord_ff == 16'h0001) ||
                      (coord_ff == 16'hFFFF);
   assign fr_drep   = fr_draw && !near_zero;
   assign hmsg      = {fr_side, header_ff[3:0], scan_pass_ff};
   assign pmsg      = {fr_drep, coord_ff};
   assign kind      = {(!have_last_ff || (pmsg != last_pos_ff)),
                       (!have_last_ff || (hmsg != last_hdr_ff))};

   always_comb begin
      phase_in         = phase_ff;
      previous_byte_in = previous_byte_ff;
      pair_first_in    = pair_first_ff;
      header_in        = header_ff;
      coord_in         = coord_ff;
      motor1_in        = motor1_ff;
      motor2_in        = motor2_ff;
      motor3_in        = motor3_ff;
      last_hdr_in      = last_hdr_ff;
      last_pos_in      = last_pos_ff;
      have_last_in     = have_last_ff;
      emit             = 1'b0;
      status_in        = ssfp_pkg::ST_GOOD;
      side_in          = 1'b0;
      sensor_in        = 4'd0;
      draw_in          = 1'b0;
      drep_in          = 1'b0;
      coord_out_in     = 16'd0;
      m1_in            = 8'd0;
      m2_in            = 8'd0;
      m3_in            = 8'd0;
      m4_in            = 8'd0;
      kind_in          = 2'd0;
      unique case (phase_ff)
         ssfp_pkg::PH_STAT_A: begin
            pair_first_in = b;
            phase_in      = ssfp_pkg::PH_STAT_B;
         end
         ssfp_pkg::PH_STAT_B: begin
            if (b != pair_first_ff) begin
               emit      = 1'b1;
               status_in = ssfp_pkg::ST_MISMATCH;
            end else if (sbits != ssfp_pkg::SIDE_TOP && sbits != ssfp_pkg::SIDE_BOTTOM) begin
               emit      = 1'b1;
               status_in = ssfp_pkg::ST_BAD_SIDE;
            end else if (dbits != ssfp_pkg::DEFECT_ABS && dbits != ssfp_pkg::DEFECT_NONE) begin
               emit      = 1'b1;
               status_in = ssfp_pkg::ST_BAD_DEF;
            end else begin
               header_in = b;
               phase_in  = ssfp_pkg::PH_HI_A;
            end
         end
         ssfp_pkg::PH_HI_A: begin
            pair_first_in = b;
            phase_in      = ssfp_pkg::PH_HI_B;
         end
         ssfp_pkg::PH_HI_B: begin
            if (b != pair_first_ff) begin
               emit      = 1'b1;
               status_in = ssfp_pkg::ST_MISMATCH;
            end else begin
               coord_in = {b, coord_ff[7:0]};
               phase_in = ssfp_pkg::PH_LO_A;
            end
         end
         ssfp_pkg::PH_LO_A: begin
            pair_first_in = b;
            phase_in      = ssfp_pkg::PH_LO_B;
         end
         ssfp_pkg::PH_LO_B: begin
            if (b != pair_first_ff) begin
               emit      = 1'b1;
               status_in = ssfp_pkg::ST_MISMATCH;
            end else begin
               coord_in = {coord_ff[15:8], b};
               phase_in = ssfp_pkg::PH_MOT1;
            end
         end
         ssfp_pkg::PH_MOT1: begin
            motor1_in = b;
            phase_in  = ssfp_pkg::PH_MOT2;
         end
         ssfp_pkg::PH_MOT2: begin
            motor2_in = b;
            phase_in  = ssfp_pkg::PH_MOT3;
         end
         ssfp_pkg::PH_MOT3: begin
            motor3_in = b;
            phase_in  = ssfp_pkg::PH_MOT4;
         end
         ssfp_pkg::PH_MOT4: begin
            emit         = 1'b1;
            status_in    = ssfp_pkg::ST_GOOD;
            side_in      = fr_side;
            sensor_in    = header_ff[3:0];
            draw_in      = fr_draw;
            drep_in      = fr_drep;
            coord_out_in = coord_ff;
            m1_in        = motor1_ff;
            m2_in        = motor2_ff;
            m3_in        = motor3_ff;
            m4_in        = b;
            kind_in      = kind;
            if (kind != 2'd0) begin
               last_hdr_in  = hmsg;
               last_pos_in  = pmsg;
               have_last_in = 1'b1;
            end
         end
         default: begin
            if (b == ssfp_pkg::SYNC_SECOND && previous_byte_ff == ssfp_pkg::SYNC_FIRST) begin
               phase_in         = ssfp_pkg::PH_STAT_A;
               previous_byte_in = 8'd0;
            end else begin
               phase_in         = ssfp_pkg::PH_HUNT;
               previous_byte_in = b;
            end
         end
      endcase
      // any ended frame restarts the hunt
      if (emit) begin
         phase_in         = ssfp_pkg::PH_HUNT;
         previous_byte_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= ssfp_pkg::PH_HUNT;
         previous_byte_ff <= 8'd0;
         last_hdr_ff      <= 6'd0;
         last_pos_ff      <= 17'd0;
         have_last_ff     <= 1'b0;
         scan_pass_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            scan_pass_ff <= csr_write_data;
         end
         if (req_fire) begin
            phase_ff         <= phase_in;
            previous_byte_ff <= previous_byte_in;
            last_hdr_ff      <= last_hdr_in;
            last_pos_ff      <= last_pos_in;
            have_last_ff     <= have_last_in;
            rsp_valid_ff     <= emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // frame payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pair_first_ff <= pair_first_in;
         header_ff     <= header_in;
         coord_ff      <= coord_in;
         motor1_ff     <= motor1_in;
         motor2_ff     <= motor2_in;
         motor3_ff     <= motor3_in;
      end
      if (req_fire && emit) begin
         status_ff    <= status_in;
         side_ff      <= side_in;
         sensor_ff    <= sensor_in;
         draw_ff      <= draw_in;
         drep_ff      <= drep_in;
         coord_out_ff <= coord_out_in;
         m1_ff        <= m1_in;
         m2_ff        <= m2_in;
         m3_ff        <= m3_in;
         m4_ff        <= m4_in;
         kind_ff      <= kind_in;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_frame_status         = status_ff;
   assign rsp_side                 = side_ff;
   assign rsp_sensor_number        = sensor_ff;
   assign rsp_defect_raw           = draw_ff;
   assign rsp_defect_reported      = drep_ff;
   assign rsp_coordinate           = $signed(coord_out_ff);
   assign rsp_motor_one_position   = m1_ff;
   assign rsp_motor_two_position   = m2_ff;
   assign rsp_motor_three_position = m3_ff;
   assign rsp_motor_four_position  = m4_ff;
   assign rsp_change_kind          = kind_ff;

   // error words carry only the status
   `SSFP_ASSERT_NOW(a_err_fields_zero, clock, reset,
      rsp_valid_ff && status_ff != ssfp_pkg::ST_GOOD,
      !side_ff && sensor_ff == 4'd0 && !draw_ff && coord_out_ff == 16'd0 && kind_ff == 2'd0)

   // an ended frame leaves the parser hunting with a cleared previous word
   `SSFP_ASSERT_NEXT(a_hunt_after_frame, clock, reset,
      req_fire && emit,
      phase_ff == ssfp_pkg::PH_HUNT && previous_byte_ff == 8'd0 && rsp_valid_ff)

   // the first recorded frame flags both changes
   `SSFP_ASSERT_NOW(a_first_frame_kind, clock, reset,
      req_fire && phase_ff == ssfp_pkg::PH_MOT4 && !have_last_ff,
      kind == 2'b11)

   // reported defect needs a raw defect
   `SSFP_ASSERT_NOW(a_drep_implies_draw, clock, reset,
      rsp_valid_ff && drep_ff,
      draw_ff)

endmodule
